[rtl/lcp_pkg.sv]
// ----------------------------------------------------------------------------
// lcp_pkg
// Types, constants and keyword table shared by the line command parser.
// ----------------------------------------------------------------------------
package lcp_pkg;

    // width of the dial accumulator; the extension result carries its low 16 bits
    localparam int EXT_WIDTH = 16;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        KIND_PICKUP    = 3'd0,
        KIND_HANGUP    = 3'd1,
        KIND_DIAL      = 3'd2,
        KIND_CHAT_BYTE = 3'd3,
        KIND_CHAT_END  = 3'd4,
        KIND_CLOSED    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        KW_PICKUP = 2'd0,
        KW_HANGUP = 2'd1,
        KW_DIAL   = 2'd2,
        KW_CHAT   = 2'd3
    } kw_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_MATCH     = 3'd1,
        PH_EXT       = 3'd2,
        PH_SKIP      = 3'd3,
        PH_SKIP_DIAL = 3'd4,
        PH_CHAT      = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] extension;
        logic [7:0]  chat_byte;
    } result_t;

    // classified byte handed from the front to the back
    typedef struct packed {
        logic            eos;
        logic [7:0]      data_byte;
        logic            is_digit;
        logic [3:0]      digit;
        logic            is_cr;
        logic            is_lf;
        logic            is_space;
        logic            start_hit;
        kw_t             start_kw;
        logic [3:0][7:0] kw_hit;
    } class_item_t;

    function automatic logic [7:0] kw_char(input kw_t kw, input logic [2:0] pos);
        logic [7:0] c;
        begin
            c = 8'h00;
            case (kw)
                KW_PICKUP:
                    case (pos)
                        3'd0: c = "p";
                        3'd1: c = "i";
                        3'd2: c = "c";
                        3'd3: c = "k";
                        3'd4: c = "u";
                        3'd5: c = "p";
                        3'd6: c = CH_CR;
                        default: c = CH_LF;
                    endcase
                KW_HANGUP:
                    case (pos)
                        3'd0: c = "h";
                        3'd1: c = "a";
                        3'd2: c = "n";
                        3'd3: c = "g";
                        3'd4: c = "u";
                        3'd5: c = "p";
                        3'd6: c = CH_CR;
                        default: c = CH_LF;
                    endcase
                KW_DIAL:
                    case (pos)
                        3'd0: c = "d";
                        3'd1: c = "i";
                        3'd2: c = "a";
                        3'd3: c = "l";
                        3'd4: c = CH_SPACE;
                        default: c = 8'h00;
                    endcase
                default:
                    case (pos)
                        3'd0: c = "c";
                        3'd1: c = "h";
                        3'd2: c = "a";
                        3'd3: c = "t";
                        default: c = 8'h00;
                    endcase
            endcase
            return c;
        end
    endfunction

    // position of the last keyword character
    function automatic logic [2:0] kw_last(input kw_t kw);
        logic [2:0] l;
        begin
            case (kw)
                KW_PICKUP: l = 3'd7;
                KW_HANGUP: l = 3'd7;
                KW_DIAL:   l = 3'd4;
                default:   l = 3'd3;
            endcase
            return l;
        end
    endfunction

endpackage

[rtl/lcp_front.sv]
// ----------------------------------------------------------------------------
// lcp_front
// Accepts stream bytes, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lcp_front
    import lcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  in_item_t    item,
    output logic        full,
    output logic        mid_valid,
    input  logic        mid_ready,
    output class_item_t mid_item
);

    class_item_t cls;
    class_item_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        wr_en, rd_en;

    always_comb
    begin
        cls.eos       = item.end_of_stream;
        cls.data_byte = item.data_byte;
        cls.is_digit  = (item.data_byte >= "0") && (item.data_byte <= "9");
        cls.digit     = item.data_byte[3:0];
        cls.is_cr     = (item.data_byte == CH_CR);
        cls.is_lf     = (item.data_byte == CH_LF);
        cls.is_space  = (item.data_byte == CH_SPACE);
        cls.start_hit = 1'b1;
        cls.start_kw  = KW_CHAT;
        case (item.data_byte)
            "p":     cls.start_kw = KW_PICKUP;
            "h":     cls.start_kw = KW_HANGUP;
            "d":     cls.start_kw = KW_DIAL;
            "c":     cls.start_kw = KW_CHAT;
            default: cls.start_hit = 1'b0;
        endcase
        // compare against every keyword character at once
        for (int k = 0; k < 4; k++)
        begin
            for (int p = 0; p < 8; p++)
            begin
                cls.kw_hit[k][p] = (item.data_byte == kw_char(kw_t'(2'(k)), 3'(p)));
            end
        end
    end

    assign full      = (count_reg == 2'd2);
    assign mid_valid = (count_reg != 2'd0);
    assign mid_item  = slot_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = mid_valid && mid_ready;

    always_comb
    begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

[rtl/lcp_back.sv]
// ----------------------------------------------------------------------------
// lcp_back
// Command parser state machine with a two-entry result queue.
// ----------------------------------------------------------------------------
module lcp_back
    import lcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        mid_valid,
    output logic        mid_ready,
    input  class_item_t mid_item,
    output logic        empty,
    input  logic        pop,
    output result_t     result
);

    phase_t                 phase_reg, phase_next;
    kw_t                    kw_reg, kw_next;
    logic [2:0]             pos_reg, pos_next;
    logic                   cr_reg, cr_next;
    logic [EXT_WIDTH-1:0]   acc_reg, acc_next;
    logic                   trim_reg, trim_next;

    logic [EXT_WIDTH+3:0]   acc_times;
    logic [EXT_WIDTH-1:0]   acc_sat;
    logic [EXT_WIDTH+15:0]  acc_wide;

    logic                   take;
    logic                   emit;
    result_t                res;

    result_t                slot_reg [2];
    logic                   wr_ptr_reg, rd_ptr_reg;
    logic [1:0]             count_reg, count_next;
    logic                   wr_en, rd_en;

    assign mid_ready = (count_reg != 2'd2);
    assign take      = mid_valid && mid_ready;

    // times ten plus digit, clamped at the accumulator maximum
    assign acc_times = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                     + {{EXT_WIDTH{1'b0}}, mid_item.digit};
    assign acc_sat   = (|acc_times[EXT_WIDTH+3:EXT_WIDTH]) ? {EXT_WIDTH{1'b1}}
                                                          : acc_times[EXT_WIDTH-1:0];
    assign acc_wide  = {16'b0, acc_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        kw_next       = kw_reg;
        pos_next      = pos_reg;
        cr_next       = cr_reg;
        acc_next      = acc_reg;
        trim_next     = trim_reg;
        emit          = 1'b0;
        res.kind      = KIND_CLOSED;
        res.extension = 16'd0;
        res.chat_byte = 8'd0;
        if (mid_item.eos)
        begin
            phase_next = PH_IDLE;
            kw_next    = KW_PICKUP;
            pos_next   = 3'd0;
            cr_next    = 1'b0;
            acc_next   = '0;
            trim_next  = 1'b1;
            emit       = 1'b1;
            res.kind   = KIND_CLOSED;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (mid_item.start_hit)
                    begin
                        kw_next    = mid_item.start_kw;
                        pos_next   = 3'd1;
                        phase_next = PH_MATCH;
                    end
                end
                PH_MATCH:
                begin
                    if (!mid_item.kw_hit[kw_reg][pos_reg])
                    begin
                        phase_next = PH_SKIP;
                        cr_next    = mid_item.is_cr;
                    end
                    else if (pos_reg != kw_last(kw_reg))
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                    else if (kw_reg == KW_PICKUP || kw_reg == KW_HANGUP)
                    begin
                        phase_next = PH_IDLE;
                        kw_next    = KW_PICKUP;
                        pos_next   = 3'd0;
                        cr_next    = 1'b0;
                        acc_next   = '0;
                        trim_next  = 1'b1;
                        emit       = 1'b1;
                        res.kind   = (kw_reg == KW_PICKUP) ? KIND_PICKUP : KIND_HANGUP;
                    end
                    else if (kw_reg == KW_DIAL)
                    begin
                        phase_next = PH_EXT;
                        acc_next   = '0;
                        cr_next    = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_CHAT;
                        trim_next  = 1'b1;
                        cr_next    = 1'b0;
                    end
                end
                PH_EXT:
                begin
                    if (cr_reg)
                    begin
                        if (mid_item.is_lf)
                        begin
                            phase_next    = PH_IDLE;
                            kw_next       = KW_PICKUP;
                            pos_next      = 3'd0;
                            cr_next       = 1'b0;
                            acc_next      = '0;
                            trim_next     = 1'b1;
                            emit          = 1'b1;
                            res.kind      = KIND_DIAL;
                            res.extension = acc_wide[15:0];
                        end
                        else
                        begin
                            phase_next = PH_SKIP_DIAL;
                            cr_next    = mid_item.is_cr;
                        end
                    end
                    else if (mid_item.is_cr)
                    begin
                        cr_next = 1'b1;
                    end
                    else if (mid_item.is_digit)
                    begin
                        acc_next = acc_sat;
                    end
                    else
                    begin
                        phase_next = PH_SKIP_DIAL;
                        cr_next    = 1'b0;
                    end
                end
                PH_SKIP, PH_SKIP_DIAL:
                begin
                    if (cr_reg && mid_item.is_lf)
                    begin
                        phase_next = PH_IDLE;
                        kw_next    = KW_PICKUP;
                        pos_next   = 3'd0;
                        cr_next    = 1'b0;
                        acc_next   = '0;
                        trim_next  = 1'b1;
                        // a bad dial line still reports a dial, to extension zero
                        emit       = (phase_reg == PH_SKIP_DIAL);
                        res.kind   = KIND_DIAL;
                    end
                    else
                    begin
                        cr_next = mid_item.is_cr;
                    end
                end
                PH_CHAT:
                begin
                    if (cr_reg && mid_item.is_lf)
                    begin
                        phase_next = PH_IDLE;
                        kw_next    = KW_PICKUP;
                        pos_next   = 3'd0;
                        cr_next    = 1'b0;
                        acc_next   = '0;
                        trim_next  = 1'b1;
                        emit       = 1'b1;
                        res.kind   = KIND_CHAT_END;
                    end
                    else if (mid_item.is_cr)
                    begin
                        cr_next = 1'b1;
                    end
                    else
                    begin
                        cr_next = 1'b0;
                        if (!(trim_reg && mid_item.is_space))
                        begin
                            trim_next     = 1'b0;
                            emit          = 1'b1;
                            res.kind      = KIND_CHAT_BYTE;
                            res.chat_byte = mid_item.data_byte;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    kw_next    = KW_PICKUP;
                    pos_next   = 3'd0;
                    cr_next    = 1'b0;
                    acc_next   = '0;
                    trim_next  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kw_reg    <= KW_PICKUP;
            pos_reg   <= 3'd0;
            cr_reg    <= 1'b0;
            acc_reg   <= '0;
            trim_reg  <= 1'b1;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            kw_reg    <= kw_next;
            pos_reg   <= pos_next;
            cr_reg    <= cr_next;
            acc_reg   <= acc_next;
            trim_reg  <= trim_next;
        end
    end

    // result queue
    assign empty  = (count_reg == 2'd0);
    assign result = slot_reg[rd_ptr_reg];
    assign wr_en  = take && emit;
    assign rd_en  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_en ? !wr_ptr_reg : wr_ptr_reg;
            rd_ptr_reg <= rd_en ? !rd_ptr_reg : rd_ptr_reg;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

[rtl/line_command_parser.sv]
// ----------------------------------------------------------------------------
// line_command_parser
// Parses CRLF-terminated text commands from a byte stream.
// ----------------------------------------------------------------------------
// Input side: push one byte (or an end-of-stream mark) per transaction while
// full is low. Result side: the oldest result sits on result while empty is
// low and leaves on pop. Each byte gives zero or one result.
// An accepted byte is written to the byte queue; the parser then takes it and
// writes its result to the result queue. Throughput: one byte per cycle
// while the result queue has room, as the parser state updates per byte taken.
// A two-entry queue of classified bytes separates the byte classifier from
// the parser; a two-entry result queue separates the parser from the reader.
// While pop stays low the result queue fills, the parser stops, the byte
// queue fills and full rises; nothing is dropped.
// Reset empties both queues and returns the parser to waiting for a command.
// ----------------------------------------------------------------------------
module line_command_parser
    import lcp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    output logic     full,
    output logic     empty,
    input  logic     pop,
    output result_t  result
);

    logic        mid_valid;
    logic        mid_ready;
    class_item_t mid_item;

    lcp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_item  (mid_item)
    );

    lcp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_item  (mid_item),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // both queues come out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> empty && !full)
        else $error("queues not empty after reset");

    a_ext_only_dial: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_DIAL) |-> result.extension == 16'd0)
        else $error("extension set on a non-dial result");

    a_byte_only_chat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_CHAT_BYTE) |-> result.chat_byte == 8'd0)
        else $error("chat byte set on a non-chat result");

    // the parser only takes a byte when the byte queue holds one
    a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !mid_valid) |=> empty)
        else $error("result appeared with no byte to parse");

endmodule
